// ===== sv/dcbg_pkg.sv =====
package dcbg_pkg;

  localparam int unsigned VOLT_W = 10;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned WR_DATA_W = 16;
  localparam int unsigned WR_INDEX_W = 2;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned ACC_W = 19;
  localparam int unsigned HALF_W = 18;
  localparam int unsigned OFF_W = 17;
  localparam int unsigned THR_W = VOLT_W + GAIN_W;
  localparam int unsigned HYST_W = GAIN_W + 4;
  localparam int unsigned CMP_W = SAMPLE_W + 2;

  localparam logic [WR_INDEX_W-1:0] REG_BRAKE_VOLTAGE = 2'd0;
  localparam logic [WR_INDEX_W-1:0] REG_VOLT_GAIN = 2'd1;
  localparam logic [WR_INDEX_W-1:0] REG_ON_TIME_STEP = 2'd2;

  localparam logic [VOLT_W-1:0] BRAKE_VOLTAGE_RESET = 10'd360;
  localparam logic [GAIN_W-1:0] VOLT_GAIN_RESET = 16'd53946;
  localparam logic [STEP_W-1:0] ON_TIME_STEP_RESET = 16'd1;

  localparam logic [ACC_W-1:0] ON_ENABLE_LIMIT = 19'd19800;
  localparam logic [ACC_W-1:0] ON_ADD_LIMIT = 19'd400000;
  localparam logic [ACC_W-1:0] ON_TRIP_LEVEL = 19'd20002;
  localparam logic [OFF_W-1:0] OFF_INC_LIMIT = 17'd99998;
  localparam logic [HYST_W-1:0] HYST_STEPS = 20'd12;

  // Largest on_time_half value: half of the add limit plus one full step, less one.
  localparam logic [HALF_W-1:0] ON_HALF_MAX = 18'd232767;

  typedef struct packed {
    logic [VOLT_W-1:0] brake_voltage_setting;
    logic [GAIN_W-1:0] volt_gain;
    logic [STEP_W-1:0] on_time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bus_voltage_q24;
  } in_item_t;

  typedef struct packed {
    logic brake_on;
    logic overload_alarm;
    logic [HALF_W-1:0] on_time_half;
    logic [OFF_W-1:0] off_time_count;
  } out_item_t;

endpackage

// ===== sv/dcbg_stream_if.sv =====
interface dcbg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/dcbg_cfg_regs.sv =====
module dcbg_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [dcbg_pkg::WR_INDEX_W-1:0] wr_index,
  input  logic [dcbg_pkg::WR_DATA_W-1:0] wr_data,
  output dcbg_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_voltage_setting <= dcbg_pkg::BRAKE_VOLTAGE_RESET;
      cfg.volt_gain <= dcbg_pkg::VOLT_GAIN_RESET;
      cfg.on_time_step <= dcbg_pkg::ON_TIME_STEP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dcbg_pkg::REG_BRAKE_VOLTAGE: begin
          cfg.brake_voltage_setting <= wr_data[dcbg_pkg::VOLT_W-1:0];
        end
        dcbg_pkg::REG_VOLT_GAIN: begin
          cfg.volt_gain <= wr_data[dcbg_pkg::GAIN_W-1:0];
        end
        dcbg_pkg::REG_ON_TIME_STEP: begin
          cfg.on_time_step <= wr_data[dcbg_pkg::STEP_W-1:0];
        end
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

// ===== sv/dcbg_core.sv =====
module dcbg_core (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  dcbg_pkg::cfg_t cfg,
  input  dcbg_pkg::in_item_t sample,
  output dcbg_pkg::out_item_t result_next
);

  logic brake_active;
  logic alarm_latched;
  logic [dcbg_pkg::ACC_W-1:0] on_time_acc;
  logic [dcbg_pkg::OFF_W-1:0] off_time_ticks;

  logic brake_active_next;
  logic alarm_latched_next;
  logic [dcbg_pkg::ACC_W-1:0] on_time_acc_next;
  logic [dcbg_pkg::OFF_W-1:0] off_time_ticks_next;

  logic [dcbg_pkg::THR_W-1:0] thr;
  logic [dcbg_pkg::HYST_W-1:0] hyst;
  logic signed [dcbg_pkg::CMP_W-1:0] thr_s;
  logic signed [dcbg_pkg::CMP_W-1:0] low_s;
  logic signed [dcbg_pkg::CMP_W-1:0] volt_s;
  logic above;
  logic below;
  logic keep_on;
  logic [dcbg_pkg::ACC_W:0] acc_sum;
  logic [dcbg_pkg::ACC_W-1:0] acc_on;
  logic trip;

  assign thr = dcbg_pkg::THR_W'(cfg.brake_voltage_setting) * dcbg_pkg::THR_W'(cfg.volt_gain);
  assign hyst = dcbg_pkg::HYST_W'(cfg.volt_gain) * dcbg_pkg::HYST_STEPS;
  assign thr_s = $signed(dcbg_pkg::CMP_W'(thr));
  assign low_s = thr_s - $signed(dcbg_pkg::CMP_W'(hyst));
  assign volt_s = dcbg_pkg::CMP_W'($signed(sample.bus_voltage_q24));
  assign above = volt_s > thr_s;
  assign below = volt_s < low_s;

  // Hysteresis: switch on above the threshold when allowed, off below the low level.
  always_comb begin
    if (above) begin
      keep_on = (on_time_acc <= dcbg_pkg::ON_ENABLE_LIMIT) ? 1'b1 : brake_active;
    end else if (below) begin
      keep_on = 1'b0;
    end else begin
      keep_on = brake_active;
    end
  end

  assign acc_sum = {1'b0, on_time_acc} + (dcbg_pkg::ACC_W + 1)'(cfg.on_time_step);
  assign acc_on = (on_time_acc < dcbg_pkg::ON_ADD_LIMIT) ? acc_sum[dcbg_pkg::ACC_W-1:0]
                                                         : on_time_acc;
  assign trip = acc_on >= dcbg_pkg::ON_TRIP_LEVEL;

  always_comb begin
    alarm_latched_next = alarm_latched;
    if (keep_on) begin
      on_time_acc_next = acc_on;
      brake_active_next = ~trip;
      alarm_latched_next = alarm_latched | trip;
      off_time_ticks_next = '0;
    end else begin
      brake_active_next = 1'b0;
      on_time_acc_next = (on_time_acc != '0) ? on_time_acc - 1'b1 : on_time_acc;
      off_time_ticks_next = (off_time_ticks <= dcbg_pkg::OFF_INC_LIMIT) ?
                            off_time_ticks + 1'b1 : off_time_ticks;
    end
  end

  assign result_next.brake_on = brake_active_next;
  assign result_next.overload_alarm = alarm_latched_next;
  assign result_next.on_time_half = on_time_acc_next[dcbg_pkg::ACC_W-1:1];
  assign result_next.off_time_count = off_time_ticks_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_active <= 1'b0;
      alarm_latched <= 1'b0;
      on_time_acc <= '0;
      off_time_ticks <= '0;
    end else if (advance) begin
      brake_active <= brake_active_next;
      alarm_latched <= alarm_latched_next;
      on_time_acc <= on_time_acc_next;
      off_time_ticks <= off_time_ticks_next;
    end
  end

endmodule

// ===== sv/dc_bus_brake_chopper_guard.sv =====
// DC bus brake chopper guard. Each request on sample carries one filtered bus
// voltage in Q24 (one per 1 ms tick) and yields exactly one response on result:
// brake switch state, latched overload alarm, half the on-time accumulator and
// the off-time tick count. Requests pass an input register, then the
// hysteresis/on-time logic, then an output register, and a new request is
// taken every clock while result is not stalled; the core's state update sits
// between the input and output registers and is applied as a request advances.
// Configuration (brake voltage, volt gain, on-time step) must be written through
// wr_en/wr_index/wr_data only while no request is in flight; the block does not
// enforce this. Indexes past the last register are ignored. The
// overload alarm clears only on rst.
module dc_bus_brake_chopper_guard (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [dcbg_pkg::WR_INDEX_W-1:0] wr_index,
  input  logic [dcbg_pkg::WR_DATA_W-1:0] wr_data,
  dcbg_stream_if.sink sample,
  dcbg_stream_if.source result
);

  dcbg_pkg::cfg_t cfg;
  dcbg_pkg::in_item_t s1_data;
  dcbg_pkg::out_item_t result_next;
  logic s1_valid;
  logic out_valid;
  dcbg_pkg::out_item_t out_data;
  logic out_free;
  logic advance;

  dcbg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Output register is free when empty or being drained this cycle.
  assign out_free = ~out_valid | result.ready;
  // Advance the request held in the input register into the output register.
  assign advance = s1_valid & out_free;
  // Take a new request whenever the input register empties or moves on.
  assign sample.ready = ~s1_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  // Hold the sample payload until it advances.
  always_ff @(posedge clk) begin
    if (sample.valid & sample.ready) begin
      s1_data <= sample.data;
    end
  end

  dcbg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cfg         (cfg),
    .sample      (s1_data),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data = out_data;

  // A stalled input side only ever comes from a full, stalled output register.
  assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("input stalled without output back-pressure");

  // A request that advances shows up as a valid response on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced request lost");

  // Brake on means the off-time count was just cleared.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.brake_on) |-> (out_data.off_time_count == '0))
    else $error("brake on with nonzero off-time count");

  // Accumulator never exceeds the add limit plus one step.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.on_time_half <= dcbg_pkg::ON_HALF_MAX))
    else $error("on-time accumulator out of range");

endmodule

// ===== sim/tb_dc_bus_brake_chopper_guard.sv =====
`timescale 1ns / 1ps

module tb_dc_bus_brake_chopper_guard;

  // Run length guards. The slowest legal run is under 2k requests, each with at
  // most a full idle burst on both sides, far below the limit.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int TAIL_CYCLES = 8;
  localparam int DRAIN_TICKS = 250;
  localparam int MIX_TICKS = 250;
  localparam logic [dcbg_pkg::WR_DATA_W-1:0] VOLT_TOP = 16'd1000;
  localparam logic [dcbg_pkg::WR_DATA_W-1:0] ALL_ONES = 16'hFFFF;
  localparam logic [dcbg_pkg::WR_DATA_W-1:0] VOLT_DEF =
    dcbg_pkg::WR_DATA_W'(dcbg_pkg::BRAKE_VOLTAGE_RESET);
  // Index past the last register: the block must ignore writes to it.
  localparam logic [dcbg_pkg::WR_INDEX_W-1:0] REG_NONE = 2'd3;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {LVL_HIGH, LVL_LOW, LVL_BAND, LVL_NOISE} level_t;

  typedef struct packed {
    row_kind_t kind;
    logic [dcbg_pkg::WR_INDEX_W-1:0] reg_idx;
    logic [dcbg_pkg::WR_DATA_W-1:0] reg_val;
    logic signed [dcbg_pkg::SAMPLE_W-1:0] volts;
    logic typed;
    dcbg_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [dcbg_pkg::WR_INDEX_W-1:0] wr_index;
  logic [dcbg_pkg::WR_DATA_W-1:0] wr_data;

  dcbg_stream_if #(.T(dcbg_pkg::in_item_t)) sample_if ();
  dcbg_stream_if #(.T(dcbg_pkg::out_item_t)) result_if ();

  dc_bus_brake_chopper_guard u_top (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .sample(sample_if),
    .result(result_if)
  );

  // Guard model: configuration shadow and state, advanced once per accepted request.
  dcbg_pkg::cfg_t cfg_now;
  logic pred_brake = 1'b0;
  logic pred_alarm = 1'b0;
  logic [dcbg_pkg::ACC_W-1:0] pred_acc = '0;
  logic [dcbg_pkg::OFF_W-1:0] pred_off = '0;

  // Expected brake status words, oldest first.
  dcbg_pkg::out_item_t pending_status[$];
  dir_row_t dir_rows[$];

  // Typed-in expectation that travels with the request currently on the bus.
  logic typed_now;
  dcbg_pkg::out_item_t want_now;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int cycle_count = 0;
  int n_errors = 0;
  int n_samples = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_brake_seen = 0;
  int n_alarm_seen = 0;
  int n_ceiling_seen = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hysteresis, on-time accounting and overload latch for one tick.
  function automatic dcbg_pkg::out_item_t guard_tick(logic signed [dcbg_pkg::SAMPLE_W-1:0] v);
    longint vin;
    longint trip_lvl;
    longint rel_lvl;
    int unsigned acc;
    dcbg_pkg::out_item_t o;
    vin = longint'(v);
    // Compute both levels wide and signed: the release level can go negative.
    trip_lvl = longint'(cfg_now.brake_voltage_setting) * longint'(cfg_now.volt_gain);
    rel_lvl = trip_lvl - longint'(cfg_now.volt_gain) * longint'(dcbg_pkg::HYST_STEPS);
    if (vin > trip_lvl) begin
      // Re-enable only once the accumulator has cooled down to the enable limit.
      if (pred_acc <= dcbg_pkg::ON_ENABLE_LIMIT) pred_brake = 1'b1;
    end else if (vin < rel_lvl) begin
      pred_brake = 1'b0;
    end
    if (pred_brake) begin
      acc = 32'(pred_acc);
      if (acc < dcbg_pkg::ON_ADD_LIMIT) acc = acc + 32'(cfg_now.on_time_step);
      // Force off in the same tick that crosses the trip level.
      if (acc >= dcbg_pkg::ON_TRIP_LEVEL) begin
        pred_alarm = 1'b1;
        pred_brake = 1'b0;
      end
      pred_acc = acc[dcbg_pkg::ACC_W-1:0];
      pred_off = '0;
    end else begin
      if (pred_acc != '0) pred_acc = pred_acc - 1'b1;
      if (pred_off <= dcbg_pkg::OFF_INC_LIMIT) pred_off = pred_off + 1'b1;
    end
    o.brake_on = pred_brake;
    o.overload_alarm = pred_alarm;
    o.on_time_half = pred_acc[dcbg_pkg::ACC_W-1:1];
    o.off_time_count = pred_off;
    return o;
  endfunction

  // Draw a bus voltage relative to the current trip and release levels.
  function automatic logic signed [dcbg_pkg::SAMPLE_W-1:0] pick_level(level_t lvl);
    longint trip_lvl;
    longint rel_lvl;
    longint v;
    trip_lvl = longint'(cfg_now.brake_voltage_setting) * longint'(cfg_now.volt_gain);
    rel_lvl = trip_lvl - longint'(cfg_now.volt_gain) * longint'(dcbg_pkg::HYST_STEPS);
    case (lvl)
      LVL_HIGH: begin
        case ($urandom_range(0, 5))
          0: v = trip_lvl + 1;
          1: v = 64'sd2147483647;
          default: v = trip_lvl + 1 + $urandom_range(0, 2_000_000);
        endcase
      end
      LVL_LOW: begin
        case ($urandom_range(0, 5))
          0: v = rel_lvl - 1;
          1: v = -64'sd2147483648;
          default: v = rel_lvl - 1 - $urandom_range(0, 2_000_000);
        endcase
      end
      LVL_BAND: begin
        case ($urandom_range(0, 5))
          0: v = trip_lvl;
          1: v = rel_lvl;
          default: v = rel_lvl + longint'($urandom) % (trip_lvl - rel_lvl + 1);
        endcase
      end
      default: v = longint'($signed($urandom));
    endcase
    return v[dcbg_pkg::SAMPLE_W-1:0];
  endfunction

  // Random register value in a range, sized to the write port.
  function automatic logic [dcbg_pkg::WR_DATA_W-1:0] rand_data(int unsigned lo,
                                                              int unsigned hi);
    return dcbg_pkg::WR_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic show_diff(string field, logic [31:0] want_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    n_errors++;
  endtask

  // Scoreboard: check the result request first, then predict for the sample request.
  always @(posedge clk) begin : score
    dcbg_pkg::out_item_t got;
    dcbg_pkg::out_item_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.data;
        if (pending_status.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          n_errors++;
        end else begin
          want = pending_status.pop_front();
          n_checked++;
          if (got.brake_on !== want.brake_on)
            show_diff("brake_on", 32'(want.brake_on), 32'(got.brake_on));
          if (got.overload_alarm !== want.overload_alarm)
            show_diff("overload_alarm", 32'(want.overload_alarm), 32'(got.overload_alarm));
          if (got.on_time_half !== want.on_time_half)
            show_diff("on_time_half", 32'(want.on_time_half), 32'(got.on_time_half));
          if (got.off_time_count !== want.off_time_count)
            show_diff("off_time_count", 32'(want.off_time_count), 32'(got.off_time_count));
          if (want.brake_on) n_brake_seen++;
          if (want.overload_alarm) n_alarm_seen++;
          if (want.off_time_count == dcbg_pkg::OFF_INC_LIMIT + 1'b1) n_ceiling_seen++;
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        // Advance the model always; a typed-in row overrides what it predicts.
        want = guard_tick(sample_if.data.bus_voltage_q24);
        if (typed_now) want = want_now;
        pending_status.push_back(want);
        n_samples++;
      end
    end
  end

  // Result side back-pressure: random stall bursts.
  always @(posedge clk) begin : rx_pace
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      result_if.ready <= 1'b0;
      rx_hold <= $urandom_range(0, 16);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_status.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one sample request and hold it until accepted, then maybe idle a burst.
  task automatic send_tick(logic signed [dcbg_pkg::SAMPLE_W-1:0] v, logic typed,
                           dcbg_pkg::out_item_t want);
    sample_if.data.bus_voltage_q24 <= v;
    typed_now <= typed;
    want_now <= want;
    sample_if.valid <= 1'b1;
    do @(posedge clk); while (!(sample_if.valid && sample_if.ready));
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected status word has come back.
  task automatic settle_results();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Single-cycle register write; mirror it into the model with width masking.
  task automatic write_reg(logic [dcbg_pkg::WR_INDEX_W-1:0] idx,
                           logic [dcbg_pkg::WR_DATA_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      dcbg_pkg::REG_BRAKE_VOLTAGE:
        cfg_now.brake_voltage_setting = val[dcbg_pkg::VOLT_W-1:0];
      dcbg_pkg::REG_VOLT_GAIN: cfg_now.volt_gain = val[dcbg_pkg::GAIN_W-1:0];
      dcbg_pkg::REG_ON_TIME_STEP: cfg_now.on_time_step = val[dcbg_pkg::STEP_W-1:0];
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_guard(logic [dcbg_pkg::WR_DATA_W-1:0] volts,
                           logic [dcbg_pkg::WR_DATA_W-1:0] gain,
                           logic [dcbg_pkg::WR_DATA_W-1:0] step);
    settle_results();
    write_reg(dcbg_pkg::REG_BRAKE_VOLTAGE, volts);
    write_reg(dcbg_pkg::REG_VOLT_GAIN, gain);
    write_reg(dcbg_pkg::REG_ON_TIME_STEP, step);
    n_settings++;
  endtask

  // Runs of high, low and in-band levels with some noise mixed in, so the brake
  // cycles through hysteresis, trips and cool-down repeatedly.
  task automatic run_mix(int n_ticks);
    level_t lvl;
    int run_left;
    lvl = LVL_BAND;
    run_left = 0;
    repeat (n_ticks) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        case ($urandom_range(0, 9))
          0, 1, 2: lvl = LVL_HIGH;
          3, 4, 5: lvl = LVL_LOW;
          9: lvl = LVL_NOISE;
          default: lvl = LVL_BAND;
        endcase
      end
      run_left--;
      send_tick(pick_level(lvl), 1'b0, '0);
    end
  endtask

  task automatic add_tick(logic signed [dcbg_pkg::SAMPLE_W-1:0] v);
    dir_rows.push_back('{ROW_TICK, '0, '0, v, 1'b0, '0});
  endtask

  task automatic add_tick_want(logic signed [dcbg_pkg::SAMPLE_W-1:0] v,
                               dcbg_pkg::out_item_t want);
    dir_rows.push_back('{ROW_TICK, '0, '0, v, 1'b1, want});
  endtask

  task automatic add_write(logic [dcbg_pkg::WR_INDEX_W-1:0] idx,
                           logic [dcbg_pkg::WR_DATA_W-1:0] val);
    dir_rows.push_back('{ROW_WRITE, idx, val, '0, 1'b0, '0});
  endtask

  initial begin : main
    // Drive every input to a known value and load the model with reset settings.
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    sample_if.valid <= 1'b0;
    sample_if.data <= '0;
    typed_now <= 1'b0;
    want_now <= '0;
    cfg_now = '{brake_voltage_setting: dcbg_pkg::BRAKE_VOLTAGE_RESET,
                volt_gain: dcbg_pkg::VOLT_GAIN_RESET,
                on_time_step: dcbg_pkg::ON_TIME_STEP_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table. With reset settings the trip level is 19420560 and the
    // release level 18773208.
    add_tick_want(32'sd0, '{1'b0, 1'b0, 18'd0, 17'd1});
    add_tick_want(32'sh8000_0000, '{1'b0, 1'b0, 18'd0, 17'd2});
    add_tick_want(32'sh7FFF_FFFF, '{1'b1, 1'b0, 18'd0, 17'd0});
    add_tick(32'sd19420560);
    add_tick(32'sd18773208);
    add_tick(32'sd18773207);
    add_tick(32'sd19420561);
    // Zero voltage setting, full gain: release level is negative.
    add_write(dcbg_pkg::REG_BRAKE_VOLTAGE, '0);
    add_write(dcbg_pkg::REG_VOLT_GAIN, ALL_ONES);
    add_tick(32'sd1);
    add_tick(-32'sd786420);
    add_tick(-32'sd786421);
    // Oversized setting masks down to the full 10-bit range.
    add_write(dcbg_pkg::REG_BRAKE_VOLTAGE, ALL_ONES);
    add_tick(32'sd67042306);
    add_write(REG_NONE, ALL_ONES);
    add_tick(32'sd67042305);
    // Zero gain collapses both levels onto zero.
    add_write(dcbg_pkg::REG_VOLT_GAIN, '0);
    add_tick(32'sd0);
    add_tick(-32'sd1);
    add_write(dcbg_pkg::REG_ON_TIME_STEP, '0);
    add_tick(32'sd1);
    // Large step: the brake trips and is forced off in the same tick, then
    // stays blocked while the accumulator is above the enable limit.
    add_write(dcbg_pkg::REG_ON_TIME_STEP, 16'd20000);
    add_tick(32'sd1);
    add_tick(32'sh7FFF_FFFF);
    add_tick(32'sd1);

    tx_idle_pct = 15;
    rx_idle_pct = 8;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        settle_results();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_tick(dir_rows[r].volts, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random phases, each with its own guard setting and pacing.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_guard(VOLT_DEF, dcbg_pkg::VOLT_GAIN_RESET, rand_data(20, 300));
    run_mix(MIX_TICKS);

    tx_idle_pct = 20;
    rx_idle_pct = 10;
    set_guard(VOLT_TOP, ALL_ONES, rand_data(1, 300));
    run_mix(MIX_TICKS);

    tx_idle_pct = 40;
    rx_idle_pct = 0;
    set_guard('0, rand_data(0, 65535), rand_data(1, 300));
    run_mix(MIX_TICKS);

    tx_idle_pct = 0;
    rx_idle_pct = 15;
    set_guard(rand_data(0, 1000), '0, '0);
    run_mix(MIX_TICKS);

    // Step of exactly trip level minus enable limit.
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    set_guard(ALL_ONES, ALL_ONES, 16'd202);
    run_mix(MIX_TICKS);

    tx_idle_pct = $urandom_range(0, 30);
    rx_idle_pct = $urandom_range(0, 30);
    set_guard(rand_data(0, 1023), rand_data(0, 65535), rand_data(1, 300));
    run_mix(MIX_TICKS);

    // Last stretch, no idling: one full-step trip, then an off stretch that
    // drains the accumulator back down.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_guard(VOLT_DEF, dcbg_pkg::VOLT_GAIN_RESET, ALL_ONES);
    send_tick(pick_level(LVL_HIGH), 1'b0, '0);
    repeat (DRAIN_TICKS) send_tick(pick_level(LVL_LOW), 1'b0, '0);

    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d bus samples over %0d guard settings, %0d results checked, %0d errors.",
             n_samples, n_settings, n_checked, n_errors);
    $display("Brake on in %0d results, alarm set in %0d, off-time at its ceiling in %0d.",
             n_brake_seen, n_alarm_seen, n_ceiling_seen);
    if (n_errors == 0 && pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
